[src/chroma_422_to_444_fir_upsampler_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the chroma upsampler
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CHROMA_422_TO_444_FIR_UPSAMPLER_CORE_MACROS_SVH
`define CHROMA_422_TO_444_FIR_UPSAMPLER_CORE_MACROS_SVH

// Same-cycle implication
`define CHUP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("chroma upsampler check failed");

// Next-cycle implication
`define CHUP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chroma upsampler check failed");

`endif

[src/chup_pkg.sv]
// ----------------------------------------------------------------------------
// Chroma upsampler package
// Widths, filter taps and shared types of the 4:2:2 to 4:4:4 upsampler.
// ----------------------------------------------------------------------------
package chup_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int TAP_COUNT = 12;
  // Pair output lags the newest sample by this many places
  localparam int LAG       = 6;
  // Window cell that holds the sample of the pair being produced
  localparam int CENTER    = TAP_COUNT - 1 - LAG;
  localparam int COEF_W    = 9;
  localparam int TERM_W    = 18;
  localparam int SUM_W     = 18;
  localparam int SHIFT     = 8;
  localparam int ROUND     = 128;
  localparam int GROUP     = 4;
  localparam int GROUPS    = TAP_COUNT / GROUP;
  localparam int CNT_W     = $clog2(LAG + 1);

  localparam logic signed [COEF_W-1:0] FIR_TAPS [TAP_COUNT] = '{
    -9'sd2, 9'sd6, -9'sd12, 9'sd24, -9'sd48, 9'sd160,
    9'sd160, -9'sd48, 9'sd24, -9'sd12, 9'sd6, -9'sd2
  };

  // One window cell: sample plus tags of a real line sample
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                valid;
    logic                last;
  } cell_t;

  // Pair request from the window to the filter pipeline
  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] cosited;
    logic                last;
  } pair_ctl_t;

endpackage

[src/chup_in_if.sv]
// ----------------------------------------------------------------------------
// Chroma sample channel
// Valid/ready channel carrying one chroma sample and its line-end flag.
// ----------------------------------------------------------------------------
interface chup_in_if;
  logic                          valid;
  logic                          ready;
  logic [chup_pkg::SAMPLE_W-1:0] chroma_sample;
  logic                          line_end;

  modport source (output valid, output chroma_sample, output line_end, input ready);
  modport sink   (input valid, input chroma_sample, input line_end, output ready);
endinterface

[src/chup_out_if.sv]
// ----------------------------------------------------------------------------
// Output pair channel
// Valid/ready channel carrying one cosited/interpolated chroma pair.
// ----------------------------------------------------------------------------
interface chup_out_if;
  logic                          valid;
  logic                          ready;
  logic [chup_pkg::SAMPLE_W-1:0] cosited_sample;
  logic [chup_pkg::SAMPLE_W-1:0] interpolated_sample;
  logic                          last_pair;

  modport source (output valid, output cosited_sample, output interpolated_sample,
                  output last_pair, input ready);
  modport sink   (input valid, input cosited_sample, input interpolated_sample,
                  input last_pair, output ready);
endinterface

[src/chup_cell.sv]
// ----------------------------------------------------------------------------
// Window cell
// One stage of the sample window: holds a sample, passes it to its neighbor
// on shift, and weights it by its filter tap.
// ----------------------------------------------------------------------------
module chup_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                shift,
  input  logic                                clear,
  input  logic                                consume,
  input  chup_pkg::cell_t                     feed,
  input  logic signed [chup_pkg::COEF_W-1:0]  coef,
  output chup_pkg::cell_t                     held,
  output logic signed [chup_pkg::TERM_W-1:0]  term
);

  // Load from neighbor, clear at line end, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      held <= '0;
    end else if (shift) begin
      held <= feed;
    end else if (consume) begin
      held.valid <= 1'b0;
    end
  end

  // Weight sample by tap
  assign term = $signed({1'b0, held.sample}) * coef;

endmodule

[src/chup_sum.sv]
// ----------------------------------------------------------------------------
// Filter sum and output stage
// Adds the weighted taps in two registered steps, rounds and saturates, and
// holds the finished pair in the output register.
// ----------------------------------------------------------------------------
module chup_sum (
  input  logic                                clk,
  input  logic                                rst,
  input  chup_pkg::pair_ctl_t                 ctl,
  input  logic signed [chup_pkg::TERM_W-1:0]  terms [chup_pkg::TAP_COUNT],
  output logic                                free,
  chup_out_if.source                          pairs
);

  logic                                   a_valid;
  logic [chup_pkg::SAMPLE_W-1:0]          a_cosited;
  logic                                   a_last;
  logic signed [chup_pkg::SUM_W-1:0]      a_psum [chup_pkg::GROUPS];
  logic signed [chup_pkg::SUM_W-1:0]      psum_next [chup_pkg::GROUPS];
  logic signed [chup_pkg::SUM_W-1:0]      total;
  logic [chup_pkg::SAMPLE_W-1:0]          sat;
  logic                                   out_free;

  assign out_free = !pairs.valid || pairs.ready;
  assign free     = !a_valid || out_free;

  // Partial sums over groups of taps
  always_comb begin
    for (int g = 0; g < chup_pkg::GROUPS; g++) begin
      psum_next[g] = '0;
      for (int k = 0; k < chup_pkg::GROUP; k++) begin
        psum_next[g] = psum_next[g] + chup_pkg::SUM_W'(terms[g * chup_pkg::GROUP + k]);
      end
    end
  end

  // Advance the partial-sum stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (free) begin
      a_valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && ctl.valid) begin
      a_cosited <= ctl.cosited;
      a_last    <= ctl.last;
      a_psum    <= psum_next;
    end
  end

  // Final sum, round, saturate to 0..255
  always_comb begin
    total = chup_pkg::SUM_W'(chup_pkg::ROUND);
    for (int g = 0; g < chup_pkg::GROUPS; g++) begin
      total = total + a_psum[g];
    end
    if (total[chup_pkg::SUM_W-1]) begin
      sat = '0;
    end else if (|total[chup_pkg::SUM_W-2:chup_pkg::SHIFT+chup_pkg::SAMPLE_W]) begin
      sat = '1;
    end else begin
      sat = total[chup_pkg::SHIFT+chup_pkg::SAMPLE_W-1:chup_pkg::SHIFT];
    end
  end

  // Hold the pair until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      pairs.valid <= 1'b0;
    end else if (out_free) begin
      pairs.valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && a_valid) begin
      pairs.cosited_sample      <= a_cosited;
      pairs.interpolated_sample <= sat;
      pairs.last_pair           <= a_last;
    end
  end

endmodule

[src/chroma_422_to_444_fir_upsampler_core.sv]
// ----------------------------------------------------------------------------
// 4:2:2 to 4:4:4 chroma upsampler
// Symmetric 12-tap interpolation filter over a row of window cells.
// ----------------------------------------------------------------------------
// Takes one chroma sample per cycle, unless held off by a stalled output or a
// line-end drain, and gives one pair per sample: the sample itself and a
// saturated value interpolated halfway to the next sample. The samples walk
// through a row of twelve cells; a pair is produced when a line sample reaches
// the cell six places behind the newest. After the sample flagged as line end
// the input is held off while zeros shift through the cell row to drain the
// pending pairs, and then the last pair is emitted and the row cleared. From
// the center cell a pair passes through the partial-sum register, then the
// output register, to the output.
module chroma_422_to_444_fir_upsampler_core (
  input  logic       clk,
  input  logic       rst,
  chup_in_if.sink    chroma,
  chup_out_if.source pairs
);

  chup_pkg::cell_t                     cells [chup_pkg::TAP_COUNT];
  chup_pkg::cell_t                     feeds [chup_pkg::TAP_COUNT];
  chup_pkg::cell_t                     top_feed;
  logic signed [chup_pkg::TERM_W-1:0]  terms [chup_pkg::TAP_COUNT];
  chup_pkg::pair_ctl_t                 ctl;
  logic                                free;
  logic                                emit;
  logic                                hold;
  logic                                accept;
  logic                                flush_shift;
  logic                                shift;
  logic                                clear;
  logic                                flushing;
  logic [chup_pkg::CNT_W-1:0]          flush_cnt;

  // Pair request from the center cell
  assign ctl.valid   = cells[chup_pkg::CENTER].valid;
  assign ctl.cosited = cells[chup_pkg::CENTER].sample;
  assign ctl.last    = cells[chup_pkg::CENTER].last;

  // Handshake and shift control
  assign emit        = ctl.valid && free;
  assign hold        = ctl.valid && !free;
  assign chroma.ready = !flushing && !hold;
  assign accept      = chroma.valid && chroma.ready;
  assign flush_shift = flushing && (flush_cnt != chup_pkg::CNT_W'(chup_pkg::LAG)) && !hold;
  assign shift       = accept || flush_shift;
  assign clear       = flushing && (flush_cnt == chup_pkg::CNT_W'(chup_pkg::LAG)) && emit;

  // Line-end drain sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      flushing  <= 1'b0;
      flush_cnt <= '0;
    end else if (accept && chroma.line_end) begin
      flushing  <= 1'b1;
      flush_cnt <= '0;
    end else if (flush_shift) begin
      flush_cnt <= flush_cnt + 1'b1;
    end else if (clear) begin
      flushing  <= 1'b0;
    end
  end

  // Feed the top cell with the new sample, or zero while draining
  always_comb begin
    top_feed = '0;
    if (accept) begin
      top_feed.sample = chroma.chroma_sample;
      top_feed.valid  = 1'b1;
      top_feed.last   = chroma.line_end;
    end
  end

  // Row of window cells, each fed by its upper neighbor
  for (genvar g = 0; g < chup_pkg::TAP_COUNT; g++) begin : g_cell
    if (g < chup_pkg::TAP_COUNT - 1) begin : g_link
      assign feeds[g] = cells[g+1];
    end else begin : g_top
      assign feeds[g] = top_feed;
    end

    chup_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (shift),
      .clear   (clear),
      .consume (emit && (g == chup_pkg::CENTER)),
      .feed    (feeds[g]),
      .coef    (chup_pkg::FIR_TAPS[g]),
      .held    (cells[g]),
      .term    (terms[g])
    );
  end

  // Sum, round, saturate and output register
  chup_sum u_sum (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .terms (terms),
    .free  (free),
    .pairs (pairs)
  );

endmodule

[src/chup_checker.sv]
// ----------------------------------------------------------------------------
// Chroma upsampler port checker
// Watches the top-level ports for stalls, line-end draining and reset.
// ----------------------------------------------------------------------------
`include "chroma_422_to_444_fir_upsampler_core_macros.svh"

module chup_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_line_end,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [chup_pkg::SAMPLE_W-1:0] out_cosited,
  input logic [chup_pkg::SAMPLE_W-1:0] out_interp,
  input logic                          out_last
);

  // A stalled pair stays put
  `CHUP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_cosited) && $stable(out_interp) && $stable(out_last))

  // Draining after a line end holds off the input right away
  `CHUP_ASSERT_NEXT(a_drain_start, clk, rst, in_valid && in_ready && in_line_end, !in_ready)

  // Draining lasts for at least the six zero shifts
  `CHUP_ASSERT_NEXT(a_drain_len, clk, rst, in_valid && in_ready && in_line_end, ##5 !in_ready)

  // No pair right out of reset
  `CHUP_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !out_valid)

endmodule

bind chroma_422_to_444_fir_upsampler_core chup_checker u_chup_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (chroma.valid),
  .in_ready    (chroma.ready),
  .in_line_end (chroma.line_end),
  .out_valid   (pairs.valid),
  .out_ready   (pairs.ready),
  .out_cosited (pairs.cosited_sample),
  .out_interp  (pairs.interpolated_sample),
  .out_last    (pairs.last_pair)
);

[tb/chup_pair_checker.sv]
// ----------------------------------------------------------------------------
// Chroma upsampler pair checker
// Watches the sample and pair channels, predicts every output pair with its
// own copy of the window and line count, and compares each transferred pair
// field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module chup_pair_checker (
  input  logic        clk,
  input  logic        rst,
  chup_in_if          chroma,
  chup_out_if         pairs,
  output int unsigned mismatches,
  output int unsigned outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import chup_pkg::SAMPLE_W;
  import chup_pkg::TAP_COUNT;
  import chup_pkg::LAG;

  // Interpolation taps, mirrored around the midpoint between the pair's own sample and the next
  localparam int INTERP_TAPS [TAP_COUNT] = '{
    -2, 6, -12, 24, -48, 160, 160, -48, 24, -12, 6, -2
  };
  localparam int STREAM_POS  = TAP_COUNT - 1 - LAG;

  typedef struct packed {
    logic [SAMPLE_W-1:0] cosited;
    logic [SAMPLE_W-1:0] interp;
    logic                last;
  } pair_t;

  logic [SAMPLE_W-1:0] line_window [TAP_COUNT];
  int unsigned         line_fill;
  int unsigned         error_count;
  pair_t               expected_pairs [$];

  // Filter centered on window position pos; cells past the top read zero
  function automatic logic [SAMPLE_W-1:0] interpolate(int pos);
    int acc;
    int idx;
    acc = 128;
    for (int j = 0; j < TAP_COUNT; j++) begin
      idx = pos - (LAG - 1) + j;
      if (idx >= 0 && idx < TAP_COUNT) begin
        acc += INTERP_TAPS[j] * int'(line_window[idx]);
      end
    end
    if (acc < 0) begin
      return '0;
    end
    acc = acc >>> 8;
    if (acc > 255) begin
      return 8'd255;
    end
    return acc[SAMPLE_W-1:0];
  endfunction

  function automatic void clear_line();
    for (int i = 0; i < TAP_COUNT; i++) begin
      line_window[i] = '0;
    end
    line_fill = 0;
  endfunction

  function automatic void queue_pair(int pos, logic last);
    pair_t p;
    p.cosited = line_window[pos];
    p.interp  = interpolate(pos);
    p.last    = last;
    expected_pairs.push_back(p);
  endfunction

  // Advance the window by one sample and queue the pairs it releases
  function automatic void take_sample(logic [SAMPLE_W-1:0] s, logic line_end);
    int first;
    for (int i = 0; i < TAP_COUNT - 1; i++) begin
      line_window[i] = line_window[i + 1];
    end
    line_window[TAP_COUNT-1] = s;
    if (line_fill < LAG + 1) begin
      line_fill++;
    end
    if (!line_end) begin
      if (line_fill == LAG + 1) begin
        queue_pair(STREAM_POS, 1'b0);
      end
    end else begin
      // Flush every pending pair, zeros beyond the line's end
      first = TAP_COUNT - int'(line_fill);
      for (int i = first; i < TAP_COUNT; i++) begin
        queue_pair(i, i == TAP_COUNT - 1);
      end
      clear_line();
    end
  endfunction

  function automatic void report(string field, logic [SAMPLE_W-1:0] want,
                                 logic [SAMPLE_W-1:0] actual);
    $display("%0t: %s expected %0d, actual %0d", $time, field, want, actual);
  endfunction

  function automatic void check_pair();
    pair_t want;
    bit    bad;
    if (expected_pairs.size() == 0) begin
      $display("%0t: pair with none expected, actual %0d/%0d/%0d", $time,
               pairs.cosited_sample, pairs.interpolated_sample, pairs.last_pair);
      error_count++;
      return;
    end
    want = expected_pairs.pop_front();
    bad  = 1'b0;
    if (pairs.cosited_sample !== want.cosited) begin
      report("cosited_sample", want.cosited, pairs.cosited_sample);
      bad = 1'b1;
    end
    if (pairs.interpolated_sample !== want.interp) begin
      report("interpolated_sample", want.interp, pairs.interpolated_sample);
      bad = 1'b1;
    end
    if (pairs.last_pair !== want.last) begin
      report("last_pair", SAMPLE_W'(want.last), SAMPLE_W'(pairs.last_pair));
      bad = 1'b1;
    end
    if (bad) begin
      error_count++;
    end
  endfunction

  // Sample transfers on both channels; inputs first, pairs lag by design
  always @(posedge clk) begin
    if (rst) begin
      clear_line();
      expected_pairs.delete();
    end else begin
      if (chroma.valid && chroma.ready) begin
        take_sample(chroma.chroma_sample, chroma.line_end);
      end
      if (pairs.valid && pairs.ready) begin
        check_pair();
      end
    end
    outstanding <= expected_pairs.size();
    mismatches  <= error_count;
  end

endmodule

[tb/tb_chroma_422_to_444_fir_upsampler_core.sv]
// ----------------------------------------------------------------------------
// Chroma upsampler testbench
// Drives directed and random scanlines into the upsampler with bursty input
// and a stalling output, lets the pair checker predict and compare, and
// gives the verdict once every predicted pair has been transferred.
// ----------------------------------------------------------------------------
module tb_chroma_422_to_444_fir_upsampler_core;
  timeunit 1ns;
  timeprecision 1ps;

  import chup_pkg::SAMPLE_W;

  localparam int SAMPLE_TARGET = 450;
  localparam int IDLE_LIMIT    = 2000;
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_CYCLES  = 20;
  localparam int DIRECTED_N    = 20;

  // Single-sample lines, a short line, a line with negative and overflowing
  // filter results, and a line of exactly seven samples with one bit each
  localparam logic [SAMPLE_W-1:0] DIRECTED_SAMPLES [DIRECTED_N] = '{
    8'd255, 8'd0, 8'd0, 8'd255, 8'd0,
    8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0,
    8'd128, 8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32
  };
  localparam bit DIRECTED_END [DIRECTED_N] = '{
    1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1
  };

  logic        clk;
  logic        rst;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned idle_cycles;
  int          burst_left;
  bit          long_hold_req;

  chup_in_if  chroma ();
  chup_out_if pairs ();

  chroma_422_to_444_fir_upsampler_core dut (
    .clk    (clk),
    .rst    (rst),
    .chroma (chroma),
    .pairs  (pairs)
  );

  chup_pair_checker pair_check (
    .clk         (clk),
    .rst         (rst),
    .chroma      (chroma),
    .pairs       (pairs),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one sample inside a burst, idling between bursts; hold until transfer
  task automatic send_sample(logic [SAMPLE_W-1:0] s, logic line_end);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        chroma.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    chroma.valid         <= 1'b1;
    chroma.chroma_sample <= s;
    chroma.line_end      <= line_end;
    @(posedge clk);
    while (!chroma.ready) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted pair has been transferred
  task automatic drain_pairs();
    chroma.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Stimulus and verdict
  initial begin
    int total;
    int len;
    bit paused;
    rst                  <= 1'b1;
    chroma.valid         <= 1'b0;
    chroma.chroma_sample <= '0;
    chroma.line_end      <= 1'b0;
    burst_left           = 0;
    long_hold_req        = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_N; i++) begin
      send_sample(DIRECTED_SAMPLES[i], DIRECTED_END[i]);
    end
    drain_pairs();

    // Random lines: mostly medium, some short, a few long ones
    long_hold_req = 1'b1;
    total  = 0;
    paused = 1'b0;
    while (total < SAMPLE_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1: len = $urandom_range(1, 6);
        2: len = $urandom_range(40, 90);
        default: len = $urandom_range(7, 30);
      endcase
      for (int i = 0; i < len; i++) begin
        send_sample(random_sample(), i == len - 1);
      end
      total += len;
      if (!paused && total >= SAMPLE_TARGET / 2) begin
        drain_pairs();
        paused = 1'b1;
      end
    end

    drain_pairs();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Output stalls: phases of steady, random and sparse ready, one long hold
  initial begin
    int span;
    int kind;
    bit long_hold_done;
    pairs.ready    <= 1'b0;
    long_hold_done = 1'b0;
    @(posedge clk);
    forever begin
      kind = $urandom_range(0, 2);
      span = $urandom_range(4, 60);
      repeat (span) begin
        if (long_hold_req && !long_hold_done) begin
          long_hold_done = 1'b1;
          pairs.ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end
        case (kind)
          0: pairs.ready <= 1'b1;
          1: pairs.ready <= 1'($urandom_range(0, 1));
          default: pairs.ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (chroma.valid && chroma.ready) || (pairs.valid && pairs.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

[sim.f]
+incdir+src
src/chup_pkg.sv
src/chup_in_if.sv
src/chup_out_if.sv
src/chup_cell.sv
src/chup_sum.sv
src/chroma_422_to_444_fir_upsampler_core.sv
src/chup_checker.sv
tb/chup_pair_checker.sv
tb/tb_chroma_422_to_444_fir_upsampler_core.sv
